// ----- src/sfct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfct_pkg
// Opcodes, status codes and beat payload types of the symbol frequency table.
// ----------------------------------------------------------------------------
package sfct_pkg;

  localparam logic [2:0] OP_COUNT  = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_SORT   = 3'd2;
  localparam logic [2:0] OP_BIT    = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_LOOKUP = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  symbol;
    logic [15:0] init_count;
    logic        code_bit;
    logic [15:0] query_code;
    logic [4:0]  query_length;
    logic [7:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  out_symbol;
    logic [15:0] out_count;
    logic [15:0] out_code;
    logic [4:0]  out_length;
    logic [8:0]  entry_total;
    logic [1:0]  status;
  } rsp_t;

  // Command broadcast to every cell in one cycle.
  typedef struct packed {
    logic        shift;  // walk: rotate the row by one cell toward the head
    logic        wr;     // head cell: apply update below
    logic        inc;
    logic        add_bit;
    logic        bit_val;
    logic        load;   // head cell: load appended entry
  } cmd_t;

endpackage

// ----- src/sfct_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfct_req_if / sfct_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface sfct_req_if import sfct_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfct_rsp_if import sfct_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/symbol_frequency_code_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_frequency_code_table_top
// Symbol / frequency / prefix code table built as a rotating row of cells.
// ----------------------------------------------------------------------------
// The table is a ring of DEPTH cells; cell 0 is the head, and every cycle of
// a walk rotates the whole ring by one cell, except while the head holds
// still for an update, so each entry passes the head. One request is handled
// at a time; the response register holds the result until its beat is
// taken, and only then is a new request accepted. Count, code bit, read and
// lookup make one full rotation, the end check and the response step; count
// and code bit hold the head still for the update on a hit. Append passes
// the response step, then the ring turns once and stops when the free slot
// is at the head. Clear, an unused opcode and a sort of fewer than two
// entries go straight to the response step. Sort is a bubble sort of
// used_entries-1 passes, each with one compare and one rotate step per
// position.
// ----------------------------------------------------------------------------
module symbol_frequency_code_table_top import sfct_pkg::*; #(
  parameter int DEPTH        = 256,
  parameter int COUNT_BITS   = 16,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfct_req_if.sink   req,
  sfct_rsp_if.source rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_SORT = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_APP  = 3'd4;

  logic [2:0]    state_q, state_d;
  req_t          req_q;
  logic [NW-1:0] used_q, used_d;
  logic [IW:0]   step_q, step_d;   // rotation position, 0..DEPTH
  logic [NW-1:0] pass_q, pass_d;
  logic          hit_q, hit_d;
  rsp_t          rsp_q, rsp_d;
  logic          rv_q, rv_d;
  logic          phase_q, phase_d; // sort: 0 compare step, 1 rotate step

  logic [7:0]              sym  [DEPTH];
  logic [COUNT_BITS-1:0]   cnt  [DEPTH];
  logic [MAX_CODE_LEN-1:0] code [DEPTH];
  logic [LW-1:0]           len  [DEPTH];
  cmd_t cmd;
  logic do_swap;

  // position of the entry now at the head
  logic [IW:0]   pos;
  logic          in_use;
  logic [15:0]   want;

  assign pos    = step_q;
  assign in_use = (NW'(pos) < used_q) && !pos[IW];
  always_comb begin
    want = req_q.query_code;
    if (req_q.query_length < 5'd16) want = req_q.query_code & ((16'd1 << req_q.query_length) - 1'b1);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int N = (g + 1) % DEPTH;
    logic sw_in;
    logic [7:0] sw_sym;
    logic [COUNT_BITS-1:0] sw_cnt;
    if (g == 0) begin : g_h
      assign sw_in = do_swap; assign sw_sym = sym[1]; assign sw_cnt = cnt[1];
    end else if (g == 1) begin : g_s
      assign sw_in = do_swap; assign sw_sym = sym[0]; assign sw_cnt = cnt[0];
    end else begin : g_o
      assign sw_in = 1'b0; assign sw_sym = '0; assign sw_cnt = '0;
    end
    sfct_cell #(.COUNT_BITS(COUNT_BITS), .MAX_CODE_LEN(MAX_CODE_LEN), .LEN_BITS(LW)) u_cell (
      .clk_i, .cmd_i(cmd), .head_i(g == 0),
      .nxt_sym_i(sym[N]), .nxt_cnt_i(cnt[N]), .nxt_code_i(code[N]), .nxt_len_i(len[N]),
      .ld_sym_i(req_q.symbol),
      .ld_cnt_i((COUNT_BITS < 16 && req_q.init_count > 16'(CntMax)) ? CntMax
                : COUNT_BITS'(req_q.init_count)),
      .swap_in_i(sw_in), .sw_sym_i(sw_sym), .sw_cnt_i(sw_cnt),
      .sym_o(sym[g]), .cnt_o(cnt[g]), .code_o(code[g]), .len_o(len[g])
    );
  end

  function automatic rsp_t show(input logic [7:0] s, input logic [COUNT_BITS-1:0] c,
                                input logic [MAX_CODE_LEN-1:0] k, input logic [LW-1:0] l);
    rsp_t r;
    r = '0;
    r.found = 1'b1;
    r.out_symbol = s;
    r.out_count = 16'(c);
    r.out_code = 16'(k);
    r.out_length = 5'(l);
    return r;
  endfunction

  logic [COUNT_BITS-1:0] cnt_nx;
  assign cnt_nx = (cnt[0] != CntMax) ? cnt[0] + 1'b1 : cnt[0];

  always_comb begin
    state_d = state_q; used_d = used_q; step_d = step_q; pass_d = pass_q;
    hit_d = hit_q; rsp_d = rsp_q; rv_d = rv_q; phase_d = phase_q;
    cmd = '0; do_swap = 1'b0;
    if (rv_q && rsp.ready) rv_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid && !rv_q) begin
          step_d = '0; hit_d = 1'b0; pass_d = '0; phase_d = 1'b0;
          rsp_d = '0;
          unique case (req.data.opcode)
            OP_APPEND, OP_CLEAR: state_d = S_RESP;
            OP_SORT: state_d = (used_q >= NW'(2)) ? S_SORT : S_RESP;
            OP_COUNT, OP_BIT, OP_READ, OP_LOOKUP: state_d = S_WALK;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_WALK: begin
        if (step_q == (IW+1)'(DEPTH)) begin
          state_d = S_RESP;
        end else begin
          cmd.shift = 1'b1;
          step_d = step_q + 1'b1;
          if (in_use && !hit_q) begin
            unique case (req_q.opcode)
              OP_COUNT: if (sym[0] == req_q.symbol) begin
                hit_d = 1'b1;
                rsp_d = show(sym[0], cnt_nx, code[0], len[0]);
                cmd.shift = 1'b0; cmd.wr = 1'b1; cmd.inc = 1'b1;
                step_d = step_q;   // re-visit next cycle; hit now set
              end
              OP_BIT: if (sym[0] == req_q.symbol) begin
                hit_d = 1'b1;
                cmd.shift = 1'b0; step_d = step_q;
                if ({{(32-LW){1'b0}}, len[0]} >= MAX_CODE_LEN) begin
                  rsp_d = show(sym[0], cnt[0], code[0], len[0]);
                  rsp_d.status = ST_LONG;
                end else begin
                  cmd.wr = 1'b1; cmd.add_bit = 1'b1; cmd.bit_val = req_q.code_bit;
                  rsp_d = show(sym[0], cnt[0], {code[0][MAX_CODE_LEN-2:0], req_q.code_bit},
                               len[0] + 1'b1);
                end
              end
              OP_READ: if (pos[IW-1:0] == IW'(req_q.entry_index) &&
                           {24'd0, req_q.entry_index} < 32'(DEPTH)) begin
                hit_d = 1'b1;
                rsp_d = show(sym[0], cnt[0], code[0], len[0]);
              end
              OP_LOOKUP: if (req_q.query_length <= 5'(MAX_CODE_LEN) &&
                             {{(32-LW){1'b0}}, len[0]} == 32'(req_q.query_length) &&
                             32'(code[0]) == 32'(want)) begin
                hit_d = 1'b1;
                rsp_d = show(sym[0], cnt[0], code[0], len[0]);
              end
              default: ;
            endcase
          end
        end
      end
      S_SORT: begin
        // phase 0: compare head pair (positions step, step+1); phase 1: rotate
        if (!phase_q) begin
          if ((NW'(step_q) + NW'(1)) < used_q && cnt[1] > cnt[0]) do_swap = 1'b1;
          phase_d = 1'b1;
        end else begin
          cmd.shift = 1'b1;
          phase_d = 1'b0;
          if (step_q == (IW+1)'(DEPTH - 1)) begin
            step_d = '0;
            if (pass_q + NW'(2) >= used_q) state_d = S_RESP;
            else pass_d = pass_q + 1'b1;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      S_RESP: begin
        unique case (req_q.opcode)
          OP_APPEND: if (used_q >= NW'(DEPTH)) rsp_d.status = ST_FULL;
          OP_CLEAR: used_d = '0;
          OP_READ: if (!hit_q) rsp_d.status = ST_RANGE;
          default: ;
        endcase
        if (req_q.opcode == OP_APPEND && used_q < NW'(DEPTH)) begin
          // append is done by walking to the free slot
          state_d = S_APP;
          step_d = '0;
        end else begin
          rsp_d.entry_total = 9'(used_d);
          rv_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_APP: begin // rotate until the free slot is at the head, load, finish the turn
        if (step_q == (IW+1)'(DEPTH)) begin
          used_d = used_q + 1'b1;
          rsp_d.entry_total = 9'(used_d);
          rv_d = 1'b1;
          state_d = S_IDLE;
        end else if (!hit_q && NW'(step_q) == used_q) begin
          cmd.load = 1'b1;
          hit_d = 1'b1;
          rsp_d = show(req_q.symbol,
                       (COUNT_BITS < 16 && req_q.init_count > 16'(CntMax)) ? CntMax
                       : COUNT_BITS'(req_q.init_count), '0, '0);
        end else begin
          cmd.shift = 1'b1;
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; step_q <= '0; pass_q <= '0;
      hit_q <= 1'b0; rv_q <= 1'b0; phase_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; pass_q <= pass_d;
      hit_q <= hit_d; rv_q <= rv_d; phase_q <= phase_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == S_IDLE && req.valid && !rv_q) req_q <= req.data;
  end

  assign req.ready = (state_q == S_IDLE) && !rv_q;
  assign rsp.valid = rv_q;
  assign rsp.data  = rsp_q;

endmodule

// ----- src/sfct_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfct_cell
// One table entry. Shifts its contents to the previous cell on a walk step.
// ----------------------------------------------------------------------------
module sfct_cell import sfct_pkg::*; #(
  parameter int COUNT_BITS   = 16,
  parameter int MAX_CODE_LEN = 16,
  parameter int LEN_BITS     = 5
) (
  input  logic                    clk_i,
  input  cmd_t                    cmd_i,
  input  logic                    head_i,     // this cell is the head
  input  logic [7:0]              nxt_sym_i,
  input  logic [COUNT_BITS-1:0]   nxt_cnt_i,
  input  logic [MAX_CODE_LEN-1:0] nxt_code_i,
  input  logic [LEN_BITS-1:0]     nxt_len_i,
  input  logic [7:0]              ld_sym_i,
  input  logic [COUNT_BITS-1:0]   ld_cnt_i,
  // sort: head receives second cell's sym/count, second receives head's
  input  logic                    swap_in_i,
  input  logic [7:0]              sw_sym_i,
  input  logic [COUNT_BITS-1:0]   sw_cnt_i,
  output logic [7:0]              sym_o,
  output logic [COUNT_BITS-1:0]   cnt_o,
  output logic [MAX_CODE_LEN-1:0] code_o,
  output logic [LEN_BITS-1:0]     len_o
);

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [7:0]              sym_q, sym_d;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
  logic [MAX_CODE_LEN-1:0] code_q, code_d;
  logic [LEN_BITS-1:0]     len_q, len_d;

  always_comb begin
    sym_d = sym_q; cnt_d = cnt_q; code_d = code_q; len_d = len_q;
    if (cmd_i.shift) begin
      sym_d = nxt_sym_i; cnt_d = nxt_cnt_i; code_d = nxt_code_i; len_d = nxt_len_i;
    end else if (swap_in_i) begin
      sym_d = sw_sym_i; cnt_d = sw_cnt_i;
    end else if (head_i && cmd_i.load) begin
      sym_d = ld_sym_i; cnt_d = ld_cnt_i; code_d = '0; len_d = '0;
    end else if (head_i && cmd_i.wr) begin
      if (cmd_i.inc && cnt_q != CntMax) cnt_d = cnt_q + 1'b1;
      if (cmd_i.add_bit) begin
        code_d = {code_q[MAX_CODE_LEN-2:0], cmd_i.bit_val};
        len_d  = len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; cnt_q <= cnt_d; code_q <= code_d; len_q <= len_d;
  end

  assign sym_o = sym_q;
  assign cnt_o = cnt_q;
  assign code_o = code_q;
  assign len_o = len_q;

endmodule
